@@ rtl/md5sbm_pkg.sv @@
// ----------------------------------------------------------------------------
// md5sbm_pkg
// Shared types, constants and step tables for the single-block MD5 matcher.
// ----------------------------------------------------------------------------
package md5sbm_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned MSG_WORDS  = 7;
   localparam int unsigned LEN_W      = 8;
   localparam int unsigned STEPS      = 64;
   localparam int unsigned STEP_IDX_W = 6;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

   // Block word that carries the bit length.
   localparam logic [3:0] LEN_WORD_IDX = 4'd14;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WORD0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WORD1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WORD2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WORD3 = 2'd3;

   // Rounds of the compression function.
   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;
   localparam logic [1:0] ROUND_I = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } md5sbm_state_type;

   typedef struct packed {
      logic [MSG_WORDS-1:0][WORD_W-1:0] words;
      logic [LEN_W-1:0]                 bit_length;
   } md5sbm_blk_type;

   // What one cell hands to the next.
   typedef struct packed {
      logic             valid;
      md5sbm_state_type st;
      md5sbm_blk_type   blk;
   } md5sbm_bus_type;

   typedef struct packed {
      logic [2*WORD_W-1:0] digest_ab;
      logic [2*WORD_W-1:0] digest_cd;
      logic                match;
   } md5sbm_result_type;

   function automatic logic [WORD_W-1:0] step_const(input logic [STEP_IDX_W-1:0] idx);
      logic [WORD_W-1:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] step_rot(input logic [STEP_IDX_W-1:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

   // Which block word a step consumes.
   function automatic logic [3:0] msg_index(input logic [STEP_IDX_W-1:0] idx);
      logic [3:0] w;
      case (idx[5:4])
         ROUND_F: w = idx[3:0];
         ROUND_G: w = idx[3:0] * 4'd5 + 4'd1;
         ROUND_H: w = idx[3:0] * 4'd3 + 4'd5;
         ROUND_I: w = idx[3:0] * 4'd7;
         default: w = idx[3:0];
      endcase
      return w;
   endfunction

   // Block word w: words 0..6 from the beat, word 14 the length, all else zero.
   function automatic logic [WORD_W-1:0] blk_word(input md5sbm_blk_type blk,
                                                  input logic [3:0]     w);
      logic [WORD_W-1:0] v;
      v = '0;
      if (w < 4'(MSG_WORDS)) begin
         v = blk.words[w[2:0]];
      end else if (w == LEN_WORD_IDX) begin
         v = {{(WORD_W-LEN_W){1'b0}}, blk.bit_length};
      end
      return v;
   endfunction

endpackage

@@ rtl/md5_short_block_digest_match_top.sv @@
// ----------------------------------------------------------------------------
// md5_short_block_digest_match_top
// MD5 of one short single-block message with a compare against a target.
// ----------------------------------------------------------------------------
// The block takes one candidate message per clock cycle while req_ready is
// high and returns one response beat per request beat, in order. A request
// beat carries block words 0 to 6 (the feeder has already placed the 0x80
// pad byte) and the length in bits, which becomes block word 14; all other
// words are zero. The hash is computed by a chain of 64 step cells, one MD5
// step per cell, so one beat enters and one leaves every cycle when the
// consumer keeps up. A request passes through the 64 step cells and then
// the output register, which adds the initial value and compares the digest
// with target_word0..3. A single skid entry behind the output register lets
// the chain keep moving while a response waits, until that entry fills;
// req_ready is low only while that entry is occupied. The user must write
// the target registers through csr_we/csr_index/csr_wdata only while the
// block is idle; the block does not enforce this. They reset to zero.
// ----------------------------------------------------------------------------
module md5_short_block_digest_match_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_msg_word0,
   input  logic [31:0]                          req_msg_word1,
   input  logic [31:0]                          req_msg_word2,
   input  logic [31:0]                          req_msg_word3,
   input  logic [31:0]                          req_msg_word4,
   input  logic [31:0]                          req_msg_word5,
   input  logic [31:0]                          req_msg_word6,
   input  logic [7:0]                           req_bit_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [63:0]                          rsp_digest_ab,
   output logic [63:0]                          rsp_digest_cd,
   output logic                                 rsp_match,
   input  logic                                 csr_we,
   input  logic [md5sbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);
   import md5sbm_pkg::*;

   md5sbm_state_type  target_ff;
   md5sbm_bus_type    head;
   md5sbm_bus_type    chain [STEPS+1];
   md5sbm_result_type rsp;
   logic              advance;

   // Target registers. An index with no register behind it is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_WORD0: target_ff.a <= csr_wdata;
            CSR_TARGET_WORD1: target_ff.b <= csr_wdata;
            CSR_TARGET_WORD2: target_ff.c <= csr_wdata;
            CSR_TARGET_WORD3: target_ff.d <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The first cell starts from the standard initial value.
   always_comb begin
      head.valid          = req_valid;
      head.st.a           = IV_A;
      head.st.b           = IV_B;
      head.st.c           = IV_C;
      head.st.d           = IV_D;
      head.blk.words[0]   = req_msg_word0;
      head.blk.words[1]   = req_msg_word1;
      head.blk.words[2]   = req_msg_word2;
      head.blk.words[3]   = req_msg_word3;
      head.blk.words[4]   = req_msg_word4;
      head.blk.words[5]   = req_msg_word5;
      head.blk.words[6]   = req_msg_word6;
      head.blk.bit_length = req_bit_length;
   end

   assign chain[0]  = head;
   assign req_ready = advance;

   // Cell i performs step i and registers the updated state.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      md5sbm_step_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .step_idx (STEP_IDX_W'(i)),
         .prev     (chain[i]),
         .cur      (chain[i+1])
      );
   end

   // Only the state and the valid flag of the last cell are needed here.
   md5sbm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .last_valid (chain[STEPS].valid),
      .last_st    (chain[STEPS].st),
      .target     (target_ff),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_digest_ab = rsp.digest_ab;
   assign rsp_digest_cd = rsp.digest_cd;
   assign rsp_match     = rsp.match;

endmodule

@@ rtl/md5sbm_step_cell.sv @@
// ----------------------------------------------------------------------------
// md5sbm_step_cell
// One MD5 step with its own registers; the candidate block travels along.
// ----------------------------------------------------------------------------
module md5sbm_step_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [md5sbm_pkg::STEP_IDX_W-1:0]  step_idx,
   input  md5sbm_pkg::md5sbm_bus_type         prev,
   output md5sbm_pkg::md5sbm_bus_type         cur
);
   import md5sbm_pkg::*;

   logic              valid_ff;
   md5sbm_state_type  st_ff;
   md5sbm_blk_type    blk_ff;
   md5sbm_bus_type    bus_in;
   logic [WORD_W-1:0] f_val;
   logic [WORD_W-1:0] sum;
   logic [4:0]        rot_amt;
   logic [WORD_W-1:0] rot_val;

   always_comb begin
      case (step_idx[5:4])
         ROUND_F: f_val = (prev.st.b & prev.st.c) | (~prev.st.b & prev.st.d);
         ROUND_G: f_val = (prev.st.d & prev.st.b) | (~prev.st.d & prev.st.c);
         ROUND_H: f_val = prev.st.b ^ prev.st.c ^ prev.st.d;
         ROUND_I: f_val = prev.st.c ^ (prev.st.b | ~prev.st.d);
         default: f_val = '0;
      endcase
      sum     = prev.st.a + f_val + step_const(step_idx)
              + blk_word(prev.blk, msg_index(step_idx));
      rot_amt = step_rot(step_idx);
      rot_val = (sum << rot_amt) | (sum >> (6'd32 - {1'b0, rot_amt}));

      bus_in.valid = prev.valid;
      bus_in.blk   = prev.blk;
      bus_in.st.a  = prev.st.d;
      bus_in.st.d  = prev.st.c;
      bus_in.st.c  = prev.st.b;
      bus_in.st.b  = prev.st.b + rot_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= bus_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff  <= bus_in.st;
         blk_ff <= bus_in.blk;
      end
   end

   assign cur = {valid_ff, st_ff, blk_ff};

endmodule

@@ rtl/md5sbm_out_stage.sv @@
// ----------------------------------------------------------------------------
// md5sbm_out_stage
// Adds the initial value, compares with the target and holds the result
// in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module md5sbm_out_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           last_valid,
   input  md5sbm_pkg::md5sbm_state_type   last_st,
   input  md5sbm_pkg::md5sbm_state_type   target,
   output logic                           advance,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output md5sbm_pkg::md5sbm_result_type  rsp
);
   import md5sbm_pkg::*;

   md5sbm_state_type  digest;
   md5sbm_result_type fin;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   md5sbm_result_type rsp_data_ff, rsp_data_in;
   md5sbm_result_type skid_data_ff, skid_data_in;

   // The chain only moves while the skid entry is free, so nothing is lost.
   assign advance = !skid_valid_ff;

   always_comb begin
      digest.a      = last_st.a + IV_A;
      digest.b      = last_st.b + IV_B;
      digest.c      = last_st.c + IV_C;
      digest.d      = last_st.d + IV_D;
      fin.digest_ab = {digest.b, digest.a};
      fin.digest_cd = {digest.d, digest.c};
      fin.match     = (digest == target);
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && !rsp_ready) begin
         if (advance && last_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = fin;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = advance && last_valid;
         rsp_data_in  = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without an output beat");

   a_skid_stalls_chain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !advance)
      else $error("chain advanced while skid entry full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ready |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid entry did not move to output");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid entry filled without an output stall");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-block MD5 digest matcher.
// ----------------------------------------------------------------------------
// Every accepted request beat is hashed by a behavioural MD5 model kept in
// this file, together with its own copy of the four target registers. The
// expected digest and match flag are queued, and each response beat is
// compared field by field with the oldest entry. A directed part covers the
// field extremes, inconsistent padding and every kind of near and exact
// match. A random part then plants a known candidate in each phase, points
// the targets at its digest and mixes it with well-formed messages, messages
// with a wrong length and pure noise, under random back-pressure except in one phase.
// ----------------------------------------------------------------------------
module tb;
   import md5sbm_pkg::*;

   localparam int unsigned STALL_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES  = 80;
   localparam int unsigned IDLE_PERCENT   = 27;
   localparam int unsigned RANDOM_PHASES  = 10;
   localparam int unsigned PHASE_BEATS    = 195;
   localparam int unsigned REPORT_LIMIT   = 10;

   // Additive constants of the 64 steps, index 0 leftmost.
   localparam logic [0:63][31:0] SINE_K = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotation amounts: four per round, repeated across the sixteen steps.
   localparam logic [0:15][4:0] ROT_AMT = {
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // Digest of the empty message, used to confirm the model itself.
   localparam md5sbm_state_type EMPTY_DIGEST =
      {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

   // ------------------------------------------------------------------------
   // Clock and DUT connections. Every input has a known value from time zero.
   // ------------------------------------------------------------------------
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [31:0] req_msg_word0  = '0;
   logic [31:0] req_msg_word1  = '0;
   logic [31:0] req_msg_word2  = '0;
   logic [31:0] req_msg_word3  = '0;
   logic [31:0] req_msg_word4  = '0;
   logic [31:0] req_msg_word5  = '0;
   logic [31:0] req_msg_word6  = '0;
   logic [7:0]  req_bit_length = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [63:0] rsp_digest_ab;
   logic [63:0] rsp_digest_cd;
   logic        rsp_match;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   md5_short_block_digest_match_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_msg_word0  (req_msg_word0),
      .req_msg_word1  (req_msg_word1),
      .req_msg_word2  (req_msg_word2),
      .req_msg_word3  (req_msg_word3),
      .req_msg_word4  (req_msg_word4),
      .req_msg_word5  (req_msg_word5),
      .req_msg_word6  (req_msg_word6),
      .req_bit_length (req_bit_length),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digest_ab  (rsp_digest_ab),
      .rsp_digest_cd  (rsp_digest_cd),
      .rsp_match      (rsp_match),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   md5sbm_result_type pending_digests [$];
   md5sbm_state_type  target_copy = '0;   // mirrors the target registers
   md5sbm_result_type due;
   md5sbm_blk_type    seen_blk;

   bit          steady        = 1'b0;     // no idling on either side
   int unsigned fail_count    = 0;
   int unsigned stall_cycles  = 0;
   int unsigned beats_sent    = 0;
   int unsigned beats_checked = 0;
   int unsigned hits_checked  = 0;
   int unsigned target_sets   = 0;

   // ------------------------------------------------------------------------
   // Behavioural MD5 of one 64-byte block built from a request beat.
   // ------------------------------------------------------------------------
   function automatic md5sbm_state_type md5_compress_block(input md5sbm_blk_type blk);
      logic [31:0]      m [16];
      logic [31:0]      a, b, c, d, f, t, sum;
      int unsigned      w, rnd;
      md5sbm_state_type h;
      for (int k = 0; k < 16; k++) begin
         m[k] = '0;
      end
      for (int k = 0; k < MSG_WORDS; k++) begin
         m[k] = blk.words[k];
      end
      m[LEN_WORD_IDX] = {24'b0, blk.bit_length};
      a = IV_A;
      b = IV_B;
      c = IV_C;
      d = IV_D;
      for (int unsigned i = 0; i < 64; i++) begin
         rnd = i / 16;
         case (rnd)
            0: begin
               f = (b & c) | (~b & d);
               w = i;
            end
            1: begin
               f = (d & b) | (~d & c);
               w = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               w = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               w = (7 * i) % 16;
            end
         endcase
         sum = a + f + SINE_K[i] + m[w];
         t   = d;
         d   = c;
         c   = b;
         // No rotation amount is zero, so the plain two-shift form is safe.
         b   = b + ((sum << ROT_AMT[rnd * 4 + i % 4]) |
                    (sum >> (32 - ROT_AMT[rnd * 4 + i % 4])));
         a   = t;
      end
      h.a = a + IV_A;
      h.b = b + IV_B;
      h.c = c + IV_C;
      h.d = d + IV_D;
      return h;
   endfunction

   function automatic md5sbm_result_type expected_response(input md5sbm_blk_type blk);
      md5sbm_state_type  h;
      md5sbm_result_type r;
      h           = md5_compress_block(blk);
      r.digest_ab = {h.b, h.a};
      r.digest_cd = {h.d, h.c};
      r.match     = (h == target_copy);
      return r;
   endfunction

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] ERROR: %s", $realtime, what);
      end
   endtask

   // ------------------------------------------------------------------------
   // Beat monitor: predicts on every accepted request and checks every
   // accepted response against the oldest prediction. Requests and responses
   // are both sampled at the rising edge, where the bench's own drives have
   // not yet moved.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_blk.words[0]   = req_msg_word0;
            seen_blk.words[1]   = req_msg_word1;
            seen_blk.words[2]   = req_msg_word2;
            seen_blk.words[3]   = req_msg_word3;
            seen_blk.words[4]   = req_msg_word4;
            seen_blk.words[5]   = req_msg_word5;
            seen_blk.words[6]   = req_msg_word6;
            seen_blk.bit_length = req_bit_length;
            pending_digests.push_back(expected_response(seen_blk));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_digests.size() == 0) begin
               flag_failure($sformatf("response beat with nothing expected: ab=%h cd=%h m=%b",
                                      rsp_digest_ab, rsp_digest_cd, rsp_match));
            end else begin
               due = pending_digests.pop_front();
               beats_checked++;
               if (due.match) begin
                  hits_checked++;
               end
               if (rsp_digest_ab !== due.digest_ab) begin
                  flag_failure($sformatf("digest_ab expected %h got %h",
                                         due.digest_ab, rsp_digest_ab));
               end
               if (rsp_digest_cd !== due.digest_cd) begin
                  flag_failure($sformatf("digest_cd expected %h got %h",
                                         due.digest_cd, rsp_digest_cd));
               end
               if (rsp_match !== due.match) begin
                  flag_failure($sformatf("match expected %b got %b (ab=%h)",
                                         due.match, rsp_match, due.digest_ab));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
   end

   // Consumer side: back-pressure in roughly a quarter of the cycles.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog: nothing accepted on either channel for far too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic bit producer_idles();
      return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // Sends one request beat. Valid is left high after acceptance, so that a
   // following beat can go out back to back without a dip.
   task automatic send_candidate(input md5sbm_blk_type blk);
      while (producer_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_msg_word0  <= blk.words[0];
      req_msg_word1  <= blk.words[1];
      req_msg_word2  <= blk.words[2];
      req_msg_word3  <= blk.words[3];
      req_msg_word4  <= blk.words[4];
      req_msg_word5  <= blk.words[5];
      req_msg_word6  <= blk.words[6];
      req_bit_length <= blk.bit_length;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   // Stops sending and waits for every outstanding response. The first edge
   // lets the monitor record the final request before the queue is looked at.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_digests.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TARGET_WORD0: target_copy.a = value;
         CSR_TARGET_WORD1: target_copy.b = value;
         CSR_TARGET_WORD2: target_copy.c = value;
         CSR_TARGET_WORD3: target_copy.d = value;
         default: ;
      endcase
   endtask

   // Writes all four target words on consecutive edges; only called idle.
   task automatic program_target(input md5sbm_state_type tgt);
      write_csr(CSR_TARGET_WORD0, tgt.a);
      write_csr(CSR_TARGET_WORD1, tgt.b);
      write_csr(CSR_TARGET_WORD2, tgt.c);
      write_csr(CSR_TARGET_WORD3, tgt.d);
      csr_we <= 1'b0;
      target_sets++;
   endtask

   function automatic md5sbm_blk_type fill_words(input logic [31:0] w, input logic [7:0] len);
      md5sbm_blk_type blk;
      for (int k = 0; k < MSG_WORDS; k++) begin
         blk.words[k] = w;
      end
      blk.bit_length = len;
      return blk;
   endfunction

   // A properly padded message of 0 to 27 bytes with its true bit length.
   function automatic md5sbm_blk_type well_formed_candidate();
      md5sbm_blk_type blk;
      int unsigned    nbytes;
      bit             printable;
      blk       = '0;
      nbytes    = $urandom_range(0, 27);
      printable = $urandom_range(0, 1);
      for (int unsigned k = 0; k < nbytes; k++) begin
         blk.words[k / 4][8 * (k % 4) +: 8] =
            printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      end
      blk.words[nbytes / 4][8 * (nbytes % 4) +: 8] = 8'h80;
      blk.bit_length = 8'(nbytes * 8);
      return blk;
   endfunction

   function automatic md5sbm_blk_type noise_candidate();
      md5sbm_blk_type blk;
      for (int k = 0; k < MSG_WORDS; k++) begin
         blk.words[k] = $urandom;
      end
      blk.bit_length = 8'($urandom_range(0, 255));
      return blk;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight after reset the targets are all zero, so nothing may match.
   // The empty message also confirms that the bench's own hash is right.
   task automatic test_reset_targets();
      md5sbm_blk_type blk;
      blk                 = '0;
      blk.words[0][7:0]   = 8'h80;
      if (md5_compress_block(blk) != EMPTY_DIGEST) begin
         flag_failure("bench MD5 model disagrees with the empty-message digest");
      end
      send_candidate(blk);
      send_candidate(fill_words('0, 8'd0));
      send_candidate(fill_words('1, 8'hff));
      drain_pipeline();
   endtask

   // Field extremes and blocks whose length and padding disagree: the block
   // must hash exactly what it is given.
   task automatic test_field_extremes();
      md5sbm_blk_type blk;
      send_candidate(fill_words(32'haaaaaaaa, 8'haa));
      send_candidate(fill_words(32'h55555555, 8'h55));
      // Longest legal message: 27 bytes plus the pad byte in the top lane.
      blk = fill_words(32'h41424344, 8'd216);
      blk.words[6][31:24] = 8'h80;
      send_candidate(blk);
      // Pad byte where the length says it should not be.
      blk = '0;
      blk.words[0]   = 32'h00806261;
      blk.bit_length = 8'd8;
      send_candidate(blk);
      // No pad byte at all, and a length beyond what seven words can hold.
      blk = fill_words(32'h01020304, 8'd255);
      send_candidate(blk);
      drain_pipeline();
   endtask

   // An exact match, then a target that differs from the digest in one word
   // at a time, which must never match.
   task automatic test_target_match();
      md5sbm_blk_type   abc;
      md5sbm_blk_type   other;
      md5sbm_state_type h;
      md5sbm_state_type near;
      abc            = '0;
      abc.words[0]   = 32'h80636261;
      abc.bit_length = 8'd24;
      other            = abc;
      other.bit_length = 8'd25;
      h = md5_compress_block(abc);
      program_target(h);
      send_candidate(abc);
      send_candidate(other);
      drain_pipeline();
      for (int k = 0; k < 4; k++) begin
         near = h;
         near[32 * k +: 32] = near[32 * k +: 32] ^ 32'h1;
         program_target(near);
         send_candidate(abc);
         drain_pipeline();
      end
   endtask

   // Targets at both extremes of their range.
   task automatic test_target_extremes();
      program_target('1);
      send_candidate(fill_words('1, 8'hff));
      send_candidate(fill_words('0, 8'h00));
      drain_pipeline();
      program_target('0);
      send_candidate(fill_words('0, 8'h00));
      drain_pipeline();
   endtask

   // Random traffic in phases. Each phase points the targets at the digest
   // of a planted candidate and sprinkles it among the other beats, so that
   // matches keep turning up. One phase runs with no idling on either side.
   task automatic test_random_traffic();
      md5sbm_blk_type planted;
      md5sbm_blk_type blk;
      int unsigned    roll;
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         planted = ($urandom_range(0, 3) == 0) ? noise_candidate() : well_formed_candidate();
         program_target(md5_compress_block(planted));
         steady = (phase == RANDOM_PHASES / 2);
         for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               blk = planted;
            end else if (roll < 75) begin
               blk = well_formed_candidate();
            end else if (roll < 85) begin
               // Well-formed content with a length that does not fit it.
               blk = well_formed_candidate();
               blk.bit_length = 8'($urandom_range(0, 255));
            end else begin
               blk = noise_candidate();
            end
            send_candidate(blk);
         end
         // Hold the producer until everything is back before retargeting.
         drain_pipeline();
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_targets();
      test_field_extremes();
      test_target_match();
      test_target_extremes();
      test_random_traffic();

      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_digests.size() != 0) begin
         flag_failure($sformatf("%0d responses never arrived", pending_digests.size()));
      end

      $display("Hashed %0d candidates and checked %0d responses, %0d of them matches,",
               beats_sent, beats_checked, hits_checked);
      $display("across %0d target settings; %0d failures seen.", target_sets, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/md5sbm_pkg.sv
rtl/md5sbm_step_cell.sv
rtl/md5sbm_out_stage.sv
rtl/md5_short_block_digest_match_top.sv
tb/tb.sv
